/* src/i2p_pkg.sv */
package i2p_pkg;

    localparam int I2P_STACK_DEPTH = 32;

    // token kinds on the input side
    localparam logic [2:0] TOK_NUM    = 3'd0;
    localparam logic [2:0] TOK_OP     = 3'd1;
    localparam logic [2:0] TOK_OPEN   = 3'd2;
    localparam logic [2:0] TOK_RPAREN = 3'd3;
    localparam logic [2:0] TOK_EOL    = 3'd4;

    // result kinds
    localparam logic [1:0] OUT_NUM = 2'd0;
    localparam logic [1:0] OUT_OP  = 2'd1;
    localparam logic [1:0] OUT_END = 2'd2;
    localparam logic [1:0] OUT_ERR = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_RPAREN   = 2'd2;
    localparam logic [1:0] ERR_LPAREN   = 2'd3;

    // stack entry: [7] left paren, [6:4] op code, [3:0] precedence
    typedef logic [7:0] entry_t;
    localparam entry_t LPAREN_ENTRY = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OP_LOOP,
        ST_RP_LOOP,
        ST_EOL_LOOP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic       direct;       // write output register at once, flagged last
        logic       direct_num;   // direct item is the input number, else an error
        logic [1:0] direct_err;
        logic       load_tok;     // latch operator token
        logic       push;
        logic       push_lparen;  // push a left paren, else the latched operator
        logic       pop;
        logic       gen;          // new item into the pending slot
        logic [1:0] gen_kind;
        logic       gen_from_top; // operator code of the generated item from top
        logic [1:0] gen_err;
        logic       finish;       // pending item out, flagged last
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic can_gen;
        logic pend_valid;
        logic empty;
        logic full;
        logic top_lparen;
        logic top_yield;
    } status_t;

endpackage

/* src/i2p_datapath.sv */
module i2p_datapath #(
    parameter int STACK_DEPTH = i2p_pkg::I2P_STACK_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  i2p_pkg::cmd_t      cmd,
    output i2p_pkg::status_t   status,
    input  logic signed [63:0] number_value,
    input  logic [2:0]         op_code,
    input  logic [3:0]         precedence,
    input  logic               right_assoc,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_kind,
    output logic signed [63:0] out_value,
    output logic [2:0]         out_op,
    output logic [1:0]         error_code,
    output logic               last
);
    import i2p_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    entry_t             stack_mem [STACK_DEPTH];
    logic [CNT_W-1:0]   count_reg, count_next;
    entry_t             top_reg;
    entry_t             push_data;
    logic [IDX_W-1:0]   rd_idx;
    logic [CNT_W-1:0]   rd_cnt;

    logic [2:0]         tok_op_reg;
    logic [3:0]         tok_prec_reg;
    logic               tok_rassoc_reg;

    logic               pend_valid_reg, pend_valid_next;
    logic [1:0]         pend_kind_reg, pend_kind_next;
    logic [2:0]         pend_op_reg, pend_op_next;
    logic [1:0]         pend_err_reg, pend_err_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_load;
    logic [1:0]         out_kind_reg, out_kind_next;
    logic signed [63:0] out_value_reg, out_value_next;
    logic [2:0]         out_op_reg, out_op_next;
    logic [1:0]         out_err_reg, out_err_next;
    logic               out_last_reg, out_last_next;
    logic               out_free;
    logic [2:0]         gen_op;

    // operator token
    always_ff @(posedge clk)
    begin
        if (cmd.load_tok)
        begin
            tok_op_reg     <= op_code;
            tok_prec_reg   <= precedence;
            tok_rassoc_reg <= right_assoc;
        end
    end

    // stack: count, storage, registered top copy
    assign push_data = cmd.push_lparen ? LPAREN_ENTRY : {1'b0, tok_op_reg, tok_prec_reg};

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.pop)
            count_next = count_reg - CNT_W'(1);
        rd_cnt = (count_next == '0) ? '0 : count_next - CNT_W'(1);
        rd_idx = rd_cnt[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
            stack_mem[count_reg[IDX_W-1:0]] <= push_data;
        // bypass a push; the popped-to entry is never being written
        if (cmd.push)
            top_reg <= push_data;
        else
            top_reg <= stack_mem[rd_idx];
    end

    // pending item and output register
    assign out_free = !out_valid_reg || out_ready;
    assign gen_op   = cmd.gen_from_top ? top_reg[6:4] : 3'd0;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_op_next    = pend_op_reg;
        pend_err_next   = pend_err_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_load        = 1'b0;
        out_kind_next   = out_kind_reg;
        out_value_next  = out_value_reg;
        out_op_next     = out_op_reg;
        out_err_next    = out_err_reg;
        out_last_next   = out_last_reg;

        if (cmd.direct)
        begin
            out_load       = 1'b1;
            out_kind_next  = cmd.direct_num ? OUT_NUM : OUT_ERR;
            out_value_next = cmd.direct_num ? number_value : 64'sd0;
            out_op_next    = 3'd0;
            out_err_next   = cmd.direct_num ? ERR_NONE : cmd.direct_err;
            out_last_next  = 1'b1;
        end
        else if ((cmd.gen && pend_valid_reg) || cmd.finish)
        begin
            out_load       = 1'b1;
            out_kind_next  = pend_kind_reg;
            out_value_next = 64'sd0;
            out_op_next    = pend_op_reg;
            out_err_next   = pend_err_reg;
            out_last_next  = cmd.finish;
        end

        if (out_load)
            out_valid_next = 1'b1;

        if (cmd.gen)
        begin
            pend_valid_next = 1'b1;
            pend_kind_next  = cmd.gen_kind;
            pend_op_next    = gen_op;
            pend_err_next   = cmd.gen_err;
        end
        else if (cmd.finish)
            pend_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_kind_reg <= pend_kind_next;
        pend_op_reg   <= pend_op_next;
        pend_err_reg  <= pend_err_next;
        out_kind_reg  <= out_kind_next;
        out_value_reg <= out_value_next;
        out_op_reg    <= out_op_next;
        out_err_reg   <= out_err_next;
        out_last_reg  <= out_last_next;
    end

    // status
    always_comb
    begin
        status.out_free   = out_free;
        status.can_gen    = !pend_valid_reg || out_free;
        status.pend_valid = pend_valid_reg;
        status.empty      = (count_reg == '0);
        status.full       = (count_reg == CNT_W'(STACK_DEPTH));
        status.top_lparen = top_reg[7];
        status.top_yield  = !top_reg[7] &&
                            (tok_rassoc_reg ? (tok_prec_reg <  top_reg[3:0])
                                            : (tok_prec_reg <= top_reg[3:0]));
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_value  = out_value_reg;
    assign out_op     = out_op_reg;
    assign error_code = out_err_reg;
    assign last       = out_last_reg;

endmodule

/* src/i2p_ctrl.sv */
module i2p_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [2:0]       token_kind,
    input  i2p_pkg::status_t status,
    output i2p_pkg::cmd_t    cmd
);
    import i2p_pkg::*;

    state_t state_reg, state_next;
    logic   in_fire;

    assign in_fire = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (token_kind)
                        TOK_OP:     state_next = ST_OP_LOOP;
                        TOK_RPAREN: state_next = ST_RP_LOOP;
                        TOK_EOL:    state_next = ST_EOL_LOOP;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_OP_LOOP:
            begin
                if (status.empty || !status.top_yield)
                begin
                    if (!status.full || status.can_gen)
                        state_next = ST_FINISH;
                end
            end
            ST_RP_LOOP:
            begin
                if (status.empty)
                begin
                    if (status.can_gen)
                        state_next = ST_FINISH;
                end
                else if (status.top_lparen)
                    state_next = ST_FINISH;
            end
            ST_EOL_LOOP:
            begin
                if (status.empty && status.can_gen)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!status.pend_valid || status.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = status.out_free;
                if (in_valid && status.out_free)
                begin
                    case (token_kind)
                        TOK_NUM:
                        begin
                            cmd.direct     = 1'b1;
                            cmd.direct_num = 1'b1;
                        end
                        TOK_OP: cmd.load_tok = 1'b1;
                        TOK_OPEN:
                        begin
                            if (status.full)
                            begin
                                cmd.direct     = 1'b1;
                                cmd.direct_err = ERR_OVERFLOW;
                            end
                            else
                            begin
                                cmd.push        = 1'b1;
                                cmd.push_lparen = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_OP_LOOP:
            begin
                if (!status.empty && status.top_yield)
                begin
                    if (status.can_gen)
                    begin
                        cmd.pop          = 1'b1;
                        cmd.gen          = 1'b1;
                        cmd.gen_kind     = OUT_OP;
                        cmd.gen_from_top = 1'b1;
                    end
                end
                else if (status.full)
                begin
                    // full stack means nothing was popped, so the slot is free
                    if (status.can_gen)
                    begin
                        cmd.gen      = 1'b1;
                        cmd.gen_kind = OUT_ERR;
                        cmd.gen_err  = ERR_OVERFLOW;
                    end
                end
                else
                    cmd.push = 1'b1;
            end
            ST_RP_LOOP:
            begin
                if (status.empty)
                begin
                    if (status.can_gen)
                    begin
                        cmd.gen      = 1'b1;
                        cmd.gen_kind = OUT_ERR;
                        cmd.gen_err  = ERR_RPAREN;
                    end
                end
                else if (status.top_lparen)
                    cmd.pop = 1'b1;
                else if (status.can_gen)
                begin
                    cmd.pop          = 1'b1;
                    cmd.gen          = 1'b1;
                    cmd.gen_kind     = OUT_OP;
                    cmd.gen_from_top = 1'b1;
                end
            end
            ST_EOL_LOOP:
            begin
                if (status.can_gen)
                begin
                    cmd.gen = 1'b1;
                    if (status.empty)
                        cmd.gen_kind = OUT_END;
                    else
                    begin
                        cmd.pop = 1'b1;
                        if (status.top_lparen)
                        begin
                            cmd.gen_kind = OUT_ERR;
                            cmd.gen_err  = ERR_LPAREN;
                        end
                        else
                        begin
                            cmd.gen_kind     = OUT_OP;
                            cmd.gen_from_top = 1'b1;
                        end
                    end
                end
            end
            ST_FINISH:
            begin
                if (status.pend_valid && status.out_free)
                    cmd.finish = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

/* src/infix_to_postfix_converter_core.sv */
// Shunting-yard infix to postfix converter over pre-parsed tokens.
// Input channel (in_valid/in_ready): one token per item - number, operator
// with precedence and associativity, left/right paren, or end of line.
// Output channel (out_valid/out_ready): postfix items - numbers, operators,
// the end marker, and error items (overflow, unmatched right or left paren).
// The final result caused by a token carries last.
// Numbers, and the overflow error of a left paren on a full stack, go
// straight to the output register and show up the cycle after acceptance;
// other left parens are only pushed. Operators, right parens and end of
// line run a pop loop at one stack entry per cycle while the receiver keeps
// up, and a stalled receiver holds the loop. Popped items go through a
// one-item holding slot so the last one can be flagged. The operator stack
// is a STACK_DEPTH-entry memory with a registered top copy; no new token is
// taken during a loop. Reset empties the stack and drops any pending
// result; no clearing pass. When the receiver stalls, the block holds its
// results and stops taking tokens until the output register frees up.
module infix_to_postfix_converter_core #(
    parameter int STACK_DEPTH = i2p_pkg::I2P_STACK_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         token_kind,
    input  logic signed [63:0] number_value,
    input  logic [2:0]         op_code,
    input  logic [3:0]         precedence,
    input  logic               right_assoc,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_kind,
    output logic signed [63:0] out_value,
    output logic [2:0]         out_op,
    output logic [1:0]         error_code,
    output logic               last
);
    import i2p_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: one token at a time
    i2p_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .token_kind (token_kind),
        .status     (status),
        .cmd        (cmd)
    );

    // stack, holding slot and output register
    i2p_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .number_value (number_value),
        .op_code      (op_code),
        .precedence   (precedence),
        .right_assoc  (right_assoc),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_kind     (out_kind),
        .out_value    (out_value),
        .out_op       (out_op),
        .error_code   (error_code),
        .last         (last)
    );

endmodule

/* sim/postfix_checker.sv */
`timescale 1ns / 1ps

module postfix_checker #(
    parameter int STACK_DEPTH = i2p_pkg::I2P_STACK_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [2:0]         token_kind,
    input  logic signed [63:0] number_value,
    input  logic [2:0]         op_code,
    input  logic [3:0]         precedence,
    input  logic               right_assoc,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         out_kind,
    input  logic signed [63:0] out_value,
    input  logic [2:0]         out_op,
    input  logic [1:0]         error_code,
    input  logic               last,
    output int                 fail_count,
    output int                 pending,
    output int                 checked_count,
    output int                 overflow_seen,
    output int                 rparen_seen,
    output int                 lparen_seen
);
    import i2p_pkg::*;

    typedef struct {
        logic [1:0]         kind;
        logic signed [63:0] value;
        logic [2:0]         op;
        logic [1:0]         err;
        logic               last;
    } postfix_item_t;

    postfix_item_t postfix_expected[$];
    postfix_item_t got_item;
    entry_t        op_stack[STACK_DEPTH];
    int unsigned   stack_fill = 0;
    int            mismatches = 0;
    int            results_seen = 0;
    int            err_tally[4] = '{default: 0};

    function automatic postfix_item_t make_item(logic [1:0] kind, logic signed [63:0] value,
                                                logic [2:0] op, logic [1:0] err);
        postfix_item_t it;
        it.kind  = kind;
        it.value = value;
        it.op    = op;
        it.err   = err;
        it.last  = 1'b0;
        return it;
    endfunction

    // shunting-yard step for one accepted token
    function automatic void predict_postfix(logic [2:0] kind, logic signed [63:0] value,
                                            logic [2:0] op, logic [3:0] prec, logic rassoc);
        postfix_item_t made[$];
        entry_t        top_e;
        logic          yielding;
        logic          matched;
        case (kind)
            TOK_NUM:
                made.push_back(make_item(OUT_NUM, value, '0, ERR_NONE));
            TOK_OP:
            begin
                yielding = 1'b1;
                while (stack_fill > 0 && yielding)
                begin
                    top_e = op_stack[stack_fill - 1];
                    yielding = !top_e[7] &&
                               (rassoc ? (prec < top_e[3:0]) : (prec <= top_e[3:0]));
                    if (yielding)
                    begin
                        made.push_back(make_item(OUT_OP, '0, top_e[6:4], ERR_NONE));
                        stack_fill--;
                    end
                end
                if (stack_fill < STACK_DEPTH)
                begin
                    op_stack[stack_fill] = {1'b0, op, prec};
                    stack_fill++;
                end
                else
                    made.push_back(make_item(OUT_ERR, '0, '0, ERR_OVERFLOW));
            end
            TOK_OPEN:
            begin
                if (stack_fill < STACK_DEPTH)
                begin
                    op_stack[stack_fill] = LPAREN_ENTRY;
                    stack_fill++;
                end
                else
                    made.push_back(make_item(OUT_ERR, '0, '0, ERR_OVERFLOW));
            end
            TOK_RPAREN:
            begin
                matched = 1'b0;
                while (stack_fill > 0 && !matched)
                begin
                    stack_fill--;
                    top_e = op_stack[stack_fill];
                    if (top_e[7])
                        matched = 1'b1;
                    else
                        made.push_back(make_item(OUT_OP, '0, top_e[6:4], ERR_NONE));
                end
                if (!matched)
                    made.push_back(make_item(OUT_ERR, '0, '0, ERR_RPAREN));
            end
            TOK_EOL:
            begin
                while (stack_fill > 0)
                begin
                    stack_fill--;
                    top_e = op_stack[stack_fill];
                    if (top_e[7])
                        made.push_back(make_item(OUT_ERR, '0, '0, ERR_LPAREN));
                    else
                        made.push_back(make_item(OUT_OP, '0, top_e[6:4], ERR_NONE));
                end
                made.push_back(make_item(OUT_END, '0, '0, ERR_NONE));
            end
            default:
                ; // unknown kinds leave no trace
        endcase
        if (made.size() > 0)
            made[made.size() - 1].last = 1'b1;
        foreach (made[i])
            postfix_expected.push_back(made[i]);
    endfunction

    function automatic void check_result(postfix_item_t got);
        postfix_item_t want;
        results_seen++;
        if (got.kind === OUT_ERR && !$isunknown(got.err))
            err_tally[got.err]++;
        if (postfix_expected.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] unexpected result: kind=%0d value=%0d op=%0d err=%0d last=%0d",
                         $realtime, got.kind, got.value, got.op, got.err, got.last);
        end
        else
        begin
            want = postfix_expected.pop_front();
            if (got.kind !== want.kind || got.value !== want.value || got.op !== want.op ||
                got.err !== want.err || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("[%0t] result %0d differs", $realtime, results_seen);
                    $display("    expected kind=%0d value=%0d op=%0d err=%0d last=%0d",
                             want.kind, want.value, want.op, want.err, want.last);
                    $display("    actual   kind=%0d value=%0d op=%0d err=%0d last=%0d",
                             got.kind, got.value, got.op, got.err, got.last);
                end
            end
        end
    endfunction

    // predict before checking: a result never leaves in its own token's cycle,
    // so FIFO order holds either way
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stack_fill = 0;
            postfix_expected.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                predict_postfix(token_kind, number_value, op_code, precedence, right_assoc);
            if (out_valid && out_ready)
            begin
                got_item      = make_item(out_kind, out_value, out_op, error_code);
                got_item.last = last;
                check_result(got_item);
            end
        end
        fail_count    <= mismatches;
        pending       <= postfix_expected.size();
        checked_count <= results_seen;
        overflow_seen <= err_tally[ERR_OVERFLOW];
        rparen_seen   <= err_tally[ERR_RPAREN];
        lparen_seen   <= err_tally[ERR_LPAREN];
    end

endmodule

/* sim/tb_infix_to_postfix_converter_core.sv */
`timescale 1ns / 1ps

module tb_infix_to_postfix_converter_core;
    import i2p_pkg::*;

    localparam int RANDOM_TOKENS = 320;
    localparam int MAX_GAP       = 12;
    // longest pop loop is a full stack plus the end marker
    localparam int DRAIN_CYCLES  = 2 * I2P_STACK_DEPTH + 20;
    localparam int CYCLE_LIMIT   = 1000000;

    // operator codes as the token stream uses them
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;

    localparam logic signed [63:0] VAL_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] VAL_MIN = 64'sh8000_0000_0000_0000;

    logic               clk;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic [2:0]         token_kind   = '0;
    logic signed [63:0] number_value = '0;
    logic [2:0]         op_code      = '0;
    logic [3:0]         precedence   = '0;
    logic               right_assoc  = 1'b0;
    logic               out_valid;
    logic               out_ready    = 1'b0;
    logic [1:0]         out_kind;
    logic signed [63:0] out_value;
    logic [2:0]         out_op;
    logic [1:0]         error_code;
    logic               last;

    int fail_count;
    int pending;
    int checked_count;
    int overflow_seen;
    int rparen_seen;
    int lparen_seen;

    int          cycle_count = 0;
    int          tokens_sent = 0;
    bit          feed_idle   = 1'b1;  // sender inserts gaps while set
    bit          sink_idle   = 1'b1;  // receiver stalls while set
    int unsigned hold_left   = 0;

    infix_to_postfix_converter_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .token_kind   (token_kind),
        .number_value (number_value),
        .op_code      (op_code),
        .precedence   (precedence),
        .right_assoc  (right_assoc),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_kind     (out_kind),
        .out_value    (out_value),
        .out_op       (out_op),
        .error_code   (error_code),
        .last         (last)
    );

    // Scoreboard: mirrors the operator stack, predicts every postfix item and
    // compares what comes out.
    postfix_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .token_kind    (token_kind),
        .number_value  (number_value),
        .op_code       (op_code),
        .precedence    (precedence),
        .right_assoc   (right_assoc),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_kind      (out_kind),
        .out_value     (out_value),
        .out_op        (out_op),
        .error_code    (error_code),
        .last          (last),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count),
        .overflow_seen (overflow_seen),
        .rparen_seen   (rparen_seen),
        .lparen_seen   (lparen_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed", cycle_count, pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result sink. After each accepted item it draws a random stall, bounded by MAX_GAP;
    // now and then the stalls are switched off to get back-to-back stretches.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if ($urandom_range(0, 39) == 0)
                sink_idle = !sink_idle;
            hold_left = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (hold_left > 0)
                out_ready <= 1'b0;
        end
        else if (!out_ready)
        begin
            if (hold_left > 0)
                hold_left--;
            if (hold_left == 0)
                out_ready <= 1'b1;
        end
    end

    // Numbers: small positive, small negative, full width random, or the extremes.
    function automatic logic signed [63:0] random_value();
        logic signed [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: v = 64'($urandom_range(0, 99));
            1: v = -64'sd1 - 64'($urandom_range(0, 99));
            2: v = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
            default: ;
        endcase
        return v;
    endfunction

    // One token. Called at a clock edge (the previous handshake or reset
    // release); returns at the edge where this token is taken. A gap drops
    // valid first; with no gap valid just stays up for the next token.
    task automatic send_token(logic [2:0] kind, logic signed [63:0] value, logic [2:0] op,
                              logic [3:0] prec, logic ra);
        int unsigned gap;
        gap = feed_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        token_kind   <= kind;
        number_value <= value;
        op_code      <= op;
        precedence   <= prec;
        right_assoc  <= ra;
        do
            @(posedge clk);
        while (!in_ready);
        if (kind <= TOK_EOL)
            tokens_sent++;
    endtask

    // Fields a token kind does not use carry junk, so the block has to ignore them.
    task automatic send_num(logic signed [63:0] value);
        send_token(TOK_NUM, value, 3'($urandom), 4'($urandom), 1'($urandom));
    endtask

    task automatic send_marker(logic [2:0] kind);
        send_token(kind, random_value(), 3'($urandom), 4'($urandom), 1'($urandom));
    endtask

    task automatic send_op(logic [2:0] op, logic [3:0] prec, logic ra);
        send_token(TOK_OP, random_value(), op, prec, ra);
    endtask

    // Half the time usual arithmetic precedence, half anything goes;
    // a few operator codes out of range ride along.
    task automatic send_random_op();
        logic [2:0] code;
        logic [3:0] prec;
        logic       ra;
        code = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
        if ($urandom_range(0, 1))
        begin
            case (code)
                OP_ADD, OP_SUB: prec = 4'd2;
                OP_MUL, OP_DIV: prec = 4'd3;
                default:        prec = 4'd4;
            endcase
            ra = (code == OP_POW);
        end
        else
        begin
            prec = 4'($urandom);
            ra   = 1'($urandom);
        end
        send_op(code, prec, ra);
    endtask

    // Well-formed infix body: operands joined by operators, parens opened
    // before an operand and closed after one. With close_all clear some
    // parens are left open on purpose.
    task automatic emit_expression(int unsigned max_nest, bit close_all);
        int unsigned open_cnt;
        int unsigned terms;
        open_cnt = 0;
        terms    = $urandom_range(1, 8);
        for (int unsigned k = 0; k < terms; k++)
        begin
            if (k > 0)
                send_random_op();
            while (open_cnt < max_nest && $urandom_range(0, 3) == 0)
            begin
                send_marker(TOK_OPEN);
                open_cnt++;
            end
            send_num(random_value());
            while (open_cnt > 0 && $urandom_range(0, 2) == 0)
            begin
                send_marker(TOK_RPAREN);
                open_cnt--;
            end
        end
        if (!close_all)
            open_cnt = $urandom_range(0, open_cnt);
        repeat (open_cnt) send_marker(TOK_RPAREN);
    endtask

    // Fill the stack to around its depth with left parens and right
    // associative top-precedence operators (those never pop each other),
    // so pushes run into overflow and the final flush is long.
    task automatic emit_deep_stack();
        int unsigned levels;
        levels = $urandom_range(I2P_STACK_DEPTH - 4, I2P_STACK_DEPTH + 3);
        repeat (levels)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                send_num(random_value());
                send_op(OP_POW, 4'd15, 1'b1);
            end
            else
                send_marker(TOK_OPEN);
        end
        send_num(random_value());
        repeat ($urandom_range(0, levels)) send_marker(TOK_RPAREN);
        send_marker(TOK_EOL);
    endtask

    // Anything at all, unknown kinds included.
    task automatic emit_noise();
        repeat ($urandom_range(1, 6))
            send_token(3'($urandom), random_value(), 3'($urandom), 4'($urandom),
                       1'($urandom));
        if ($urandom_range(0, 1))
            send_marker(TOK_EOL);
    endtask

    initial
    begin : stimulus
        int unsigned pick;
        int          random_start;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme numbers and precedences, every operator, equal
        // precedence both ways, out-of-range operator codes, ignored kinds,
        // matched empty parens, unmatched right paren with and without
        // operators on the stack, unmatched left paren at end of line.
        send_num(VAL_MAX);
        send_op(OP_ADD, 4'd0, 1'b0);
        send_num(VAL_MIN);
        send_op(OP_MUL, 4'd15, 1'b1);
        send_num(64'sd0);
        send_op(OP_POW, 4'd15, 1'b1);   // right assoc, equal precedence: no pop
        send_marker(TOK_OPEN);
        send_num(-64'sd1);
        send_op(OP_SUB, 4'd2, 1'b0);
        send_num(64'sd1);
        send_marker(TOK_RPAREN);        // pops the subtract, drops the paren
        send_op(OP_DIV, 4'd15, 1'b0);   // left assoc, equal precedence: pops both
        send_op(3'd7, 4'd8, 1'b1);      // code out of range is passed through
        send_marker(3'd5);
        send_marker(3'd7);
        send_num(64'sd42);
        send_marker(TOK_RPAREN);        // no left paren: operators, then error
        send_marker(TOK_RPAREN);        // empty stack: error alone
        send_marker(TOK_OPEN);
        send_marker(TOK_OPEN);
        send_marker(TOK_RPAREN);        // empty pair: nothing comes out
        send_op(3'd5, 4'd3, 1'b0);
        send_marker(3'd6);
        send_op(3'd6, 4'd3, 1'b0);
        send_marker(TOK_EOL);           // flush with a dangling left paren

        // Random: mostly well-formed expressions, plus stack stress, noise
        // and deliberately broken bracketing.
        random_start = tokens_sent;
        while (tokens_sent - random_start < RANDOM_TOKENS)
        begin
            if ($urandom_range(0, 3) == 0)
                feed_idle = !feed_idle;
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                emit_expression($urandom_range(0, 4), 1'b1);
                send_marker(TOK_EOL);
            end
            else if (pick < 73)
                emit_deep_stack();
            else if (pick < 85)
                emit_noise();
            else
            begin
                emit_expression($urandom_range(1, 4), 1'b0);
                if ($urandom_range(0, 1))
                    send_marker(TOK_RPAREN);
                send_marker(TOK_EOL);
            end
        end
        send_marker(TOK_EOL);
        in_valid <= 1'b0;

        // let the checker count the last token's results, then drain
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d tokens fed, %0d postfix results checked, %0d mismatches",
                 tokens_sent, checked_count, fail_count);
        $display("error items seen: overflow %0d, unmatched right %0d, unmatched left %0d",
                 overflow_seen, rparen_seen, lparen_seen);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
